@@ rtl/tlpq_pkg.sv @@
// Package for the two-level priority queue: queue depth, derived widths,
// status and command codes, register indexes. No dependencies.
package tlpq_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CAP_W       = 8;
    localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int DATA_W      = 32;
    localparam int REG_IDX_W   = 8;

    localparam logic [CAP_W-1:0]     CAP_RESET    = CAP_W'(128);
    localparam logic [REG_IDX_W-1:0] REG_HIGH_CAP = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_LOW_CAP  = REG_IDX_W'(1);

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

endpackage

@@ rtl/tlpq_if.sv @@
// Channel interfaces of the two-level priority queue: input items, result
// items and configuration writes. Depends on tlpq_pkg.
interface tlpq_in_if;
    import tlpq_pkg::*;
    logic               valid;
    logic               ready;
    t_cmd               command;
    logic signed [31:0] element;
    logic               high_priority;

    modport source (output valid, command, element, high_priority, input ready);
    modport sink   (input valid, command, element, high_priority, output ready);
endinterface

interface tlpq_out_if;
    import tlpq_pkg::*;
    logic               valid;
    logic               ready;
    t_status            status;
    logic signed [31:0] value;
    logic               from_high;

    modport source (output valid, status, value, from_high, input ready);
    modport sink   (input valid, status, value, from_high, output ready);
endinterface

interface tlpq_cfg_if;
    import tlpq_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] index;
    logic [CAP_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/tlpq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tlpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/two_level_priority_queue.sv @@
// Two-level strict priority queue. Insert, full and empty results appear in the cycle after
// the item is accepted, at one item per cycle while no remove is outstanding and the output
// is not stalled. A remove reads the head entry from its queue RAM at acceptance, and the
// registered read data then lands in the output register; no new item is taken meanwhile.
// Reset is synchronous and active low: it clears pointers, counts and the output
// register and sets both capacities to 128; the queue RAMs are not cleared.
module two_level_priority_queue (
    input  logic i_clk,
    input  logic i_rst_n,
    tlpq_in_if.sink    i_in,
    tlpq_out_if.source o_out,
    tlpq_cfg_if.sink   i_cfg
);
    import tlpq_pkg::*;

    // Capacity registers, written through the configuration channel.
    logic [CAP_W-1:0] r_hi_cap;
    logic [CAP_W-1:0] r_lo_cap;

    // Ring pointers and occupancy of each queue.
    logic [ADDR_W-1:0] r_hi_head, r_hi_tail, r_lo_head, r_lo_tail;
    logic [CNT_W-1:0]  r_hi_count, r_lo_count;

    // A remove whose read data returns from a queue RAM in the next cycle.
    logic r_pend;
    logic r_pend_high;

    // Output register.
    logic               r_out_valid;
    t_status            r_out_status;
    logic signed [31:0] r_out_value;
    logic               r_out_from_high;

    logic              in_accept;
    logic              is_insert;
    logic              hi_full, lo_full, tgt_full;
    logic              ins_ok, hi_push, lo_push, hi_pop, lo_pop;
    logic [DATA_W-1:0] hi_rdata, lo_rdata;

    // The configuration port never stalls; the user must write only while the queue is idle (not enforced here).
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi_cap <= CAP_RESET;
            r_lo_cap <= CAP_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_HIGH_CAP: r_hi_cap <= i_cfg.data;
                REG_LOW_CAP:  r_lo_cap <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // A new item is taken when no read is outstanding and the output register is
    // empty or is being emptied at this edge.
    assign i_in.ready = !r_pend && (!r_out_valid || o_out.ready);
    assign in_accept  = i_in.valid && i_in.ready;
    assign is_insert  = (i_in.command == CMD_INSERT);

    // The effective capacity is the smaller of the register and the ring depth, so
    // a queue is full once its count reaches either one. A capacity of zero, or one
    // lowered below the occupancy, therefore reports full on every insert.
    assign hi_full = (CMP_W'(r_hi_count) >= CMP_W'(r_hi_cap))
                  || (r_hi_count == CNT_W'(QUEUE_DEPTH));
    assign lo_full = (CMP_W'(r_lo_count) >= CMP_W'(r_lo_cap))
                  || (r_lo_count == CNT_W'(QUEUE_DEPTH));
    assign tgt_full = i_in.high_priority ? hi_full : lo_full;

    assign ins_ok  = in_accept && is_insert && !tgt_full;
    assign hi_push = ins_ok && i_in.high_priority;
    assign lo_push = ins_ok && !i_in.high_priority;

    // Strict priority: the high queue is served whenever it holds anything.
    assign hi_pop = in_accept && !is_insert && (r_hi_count != '0);
    assign lo_pop = in_accept && !is_insert && (r_hi_count == '0) && (r_lo_count != '0);

    // Each access happens only at acceptance, and an entry is read only after the
    // edge that wrote it, so no write and read of one entry ever share an edge.
    tlpq_ram #(.WIDTH(DATA_W), .DEPTH(QUEUE_DEPTH)) u_hi_ram (
        .i_clk   (i_clk),
        .i_we    (hi_push),
        .i_waddr (r_hi_tail),
        .i_wdata (i_in.element),
        .i_re    (hi_pop),
        .i_raddr (r_hi_head),
        .o_rdata (hi_rdata)
    );

    tlpq_ram #(.WIDTH(DATA_W), .DEPTH(QUEUE_DEPTH)) u_lo_ram (
        .i_clk   (i_clk),
        .i_we    (lo_push),
        .i_waddr (r_lo_tail),
        .i_wdata (i_in.element),
        .i_re    (lo_pop),
        .i_raddr (r_lo_head),
        .o_rdata (lo_rdata)
    );

    function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] idx);
        return (idx == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    // Pointer and count updates. A push and a pop never hit the same queue in
    // one cycle, since only one item is accepted per edge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi_head  <= '0;
            r_hi_tail  <= '0;
            r_hi_count <= '0;
            r_lo_head  <= '0;
            r_lo_tail  <= '0;
            r_lo_count <= '0;
        end else begin
            if (hi_push) begin
                r_hi_tail  <= ring_next(r_hi_tail);
                r_hi_count <= r_hi_count + 1'b1;
            end
            if (hi_pop) begin
                r_hi_head  <= ring_next(r_hi_head);
                r_hi_count <= r_hi_count - 1'b1;
            end
            if (lo_push) begin
                r_lo_tail  <= ring_next(r_lo_tail);
                r_lo_count <= r_lo_count + 1'b1;
            end
            if (lo_pop) begin
                r_lo_head  <= ring_next(r_lo_head);
                r_lo_count <= r_lo_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= hi_pop || lo_pop;
        end
        if (hi_pop || lo_pop) begin
            r_pend_high <= hi_pop;
        end
    end

    // Output register. A returning read always finds the register free, because
    // the remove was accepted only when the register was empty or being drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_pend || (in_accept && !hi_pop && !lo_pop)) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end

        if (r_pend) begin
            r_out_status    <= ST_REMOVED;
            r_out_value     <= r_pend_high ? hi_rdata : lo_rdata;
            r_out_from_high <= r_pend_high;
        end else if (in_accept && !hi_pop && !lo_pop) begin
            r_out_from_high <= 1'b0;
            if (!is_insert) begin
                r_out_status <= ST_EMPTY;
                r_out_value  <= '0;
            end else if (tgt_full) begin
                r_out_status <= ST_FULL;
                r_out_value  <= '0;
            end else begin
                r_out_status <= ST_INSERTED;
                r_out_value  <= i_in.element;
            end
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_out_status;
    assign o_out.value     = r_out_value;
    assign o_out.from_high = r_out_from_high;

`ifndef SYNTHESIS
    a_pend_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !r_out_valid)
        else $error("read data returned while the output register was occupied");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hi_count <= CNT_W'(QUEUE_DEPTH)) && (r_lo_count <= CNT_W'(QUEUE_DEPTH)))
        else $error("queue occupancy exceeds ring depth");

    a_high_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !is_insert && (r_hi_count != '0)) |=> (r_pend && r_pend_high))
        else $error("remove did not serve the nonempty high queue");

    a_no_accept_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (hi_pop || lo_pop) |=> !in_accept)
        else $error("item accepted while a queue read was outstanding");
`endif

endmodule
